[hw/rtl/lahdsr_pkg.sv]
// ---------------------------------------------------------------------------
// lahdsr_pkg
// Shared widths, codes and controller/datapath interface types for the
// linear AHDSR envelope generator.
// ---------------------------------------------------------------------------
`default_nettype none

package lahdsr_pkg;

   localparam int COUNT_WIDTH = 24;
   localparam int LEVEL_WIDTH = 16;
   localparam int PHASE_WIDTH = 3;
   localparam int CSR_INDEX_WIDTH = 3;
   localparam int CSR_DATA_WIDTH = (COUNT_WIDTH > LEVEL_WIDTH) ? COUNT_WIDTH : LEVEL_WIDTH;
   localparam int STEP_CNT_WIDTH = (LEVEL_WIDTH > 1) ? $clog2(LEVEL_WIDTH) : 1;

   // envelope phases
   localparam logic [PHASE_WIDTH-1:0] PH_ATTACK  = 3'd0;
   localparam logic [PHASE_WIDTH-1:0] PH_HOLD    = 3'd1;
   localparam logic [PHASE_WIDTH-1:0] PH_DECAY   = 3'd2;
   localparam logic [PHASE_WIDTH-1:0] PH_SUSTAIN = 3'd3;
   localparam logic [PHASE_WIDTH-1:0] PH_RELEASE = 3'd4;
   localparam logic [PHASE_WIDTH-1:0] PH_TAIL    = 3'd5;

   // register indexes
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_ATTACK_LEN    = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_HOLD_LEN      = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_DECAY_LEN     = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_SUSTAIN_LEN   = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_RELEASE_LEN   = 3'd4;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_TOTAL_LEN     = 3'd5;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_PEAK_LEVEL    = 3'd6;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_SUSTAIN_LEVEL = 3'd7;

   localparam logic [LEVEL_WIDTH-1:0] PEAK_LEVEL_RESET    = LEVEL_WIDTH'(65535);
   localparam logic [LEVEL_WIDTH-1:0] SUSTAIN_LEVEL_RESET = LEVEL_WIDTH'(32768);

   typedef struct packed {
      logic start;     // item accepted this cycle
      logic restart;   // restart bit of the accepted item
      logic advance;   // move to next phase, position to zero
      logic md_init;   // load the multiply-divide operands
      logic md_step;   // one quotient digit
      logic emit;      // load result register and update envelope state
   } lahdsr_cmd_type;

   typedef struct packed {
      logic finished;  // sample index at or past total length
      logic advance;   // current phase is used up
      logic md_last;   // final multiply-divide digit pending
      logic out_free;  // result register can take a new item
   } lahdsr_status_type;

endpackage

`default_nettype wire

[hw/rtl/lahdsr_ctrl.sv]
// ---------------------------------------------------------------------------
// lahdsr_ctrl
// Sequencer: accept a tick, skip used-up phases, run the multiply-divide
// unless finished, then hand the sample to the result register.
// ---------------------------------------------------------------------------
`default_nettype none

module lahdsr_ctrl
   import lahdsr_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire logic              req_restart,
   input  wire lahdsr_status_type status,
   output lahdsr_cmd_type         cmd
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_SKIP = 2'd1;
   localparam logic [1:0] ST_CALC = 2'd2;
   localparam logic [1:0] ST_EMIT = 2'd3;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   always_comb begin
      state_in    = state_ff;
      cmd         = '0;
      req_ready   = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.start   = 1'b1;
               cmd.restart = req_restart;
               state_in    = ST_SKIP;
            end
         end
         ST_SKIP: begin
            priority if (status.finished) begin
               state_in = ST_EMIT;
            end else if (status.advance) begin
               cmd.advance = 1'b1;
            end else begin
               cmd.md_init = 1'b1;
               state_in    = ST_CALC;
            end
         end
         ST_CALC: begin
            cmd.md_step = 1'b1;
            if (status.md_last) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

[hw/rtl/lahdsr_datapath.sv]
// ---------------------------------------------------------------------------
// lahdsr_datapath
// Config registers, envelope counters, radix-2 serial multiply-divide
// and the result register.
// ---------------------------------------------------------------------------
`default_nettype none

module lahdsr_datapath
   import lahdsr_pkg::*;
(
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       csr_valid,
   input  wire logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire logic [CSR_DATA_WIDTH-1:0]  csr_data,
   input  wire lahdsr_cmd_type             cmd,
   output lahdsr_status_type               status,
   output logic                            rsp_valid,
   input  wire logic                       rsp_ready,
   output logic [LEVEL_WIDTH-1:0]          rsp_level,
   output logic [PHASE_WIDTH-1:0]          rsp_phase,
   output logic                            rsp_last_sample,
   output logic                            rsp_finished
);

   localparam int RW = COUNT_WIDTH + 2;

   // configuration
   logic [COUNT_WIDTH-1:0] attack_len_ff, hold_len_ff, decay_len_ff;
   logic [COUNT_WIDTH-1:0] sustain_len_ff, release_len_ff, total_len_ff;
   logic [LEVEL_WIDTH-1:0] peak_level_ff, sustain_level_ff;

   // envelope state
   logic [COUNT_WIDTH-1:0] index_ff, index_in;
   logic [COUNT_WIDTH-1:0] pos_ff, pos_in;
   logic [PHASE_WIDTH-1:0] phase_ff, phase_in;

   // multiply-divide
   logic [LEVEL_WIDTH-1:0]    a_ff, a_in;
   logic [COUNT_WIDTH-1:0]    k_ff, k_in;
   logic [COUNT_WIDTH-1:0]    len_ff, len_in;
   logic [COUNT_WIDTH-1:0]    r_ff, r_in;
   logic [LEVEL_WIDTH-1:0]    q_ff, q_in;
   logic [STEP_CNT_WIDTH-1:0] cnt_ff, cnt_in;

   // result register
   logic                   out_valid_ff, out_valid_in;
   logic [LEVEL_WIDTH-1:0] out_level_ff, out_level_in;
   logic [PHASE_WIDTH-1:0] out_phase_ff, out_phase_in;
   logic                   out_last_ff, out_last_in;
   logic                   out_fin_ff, out_fin_in;

   logic [COUNT_WIDTH-1:0] cur_len;
   logic [RW-1:0]          r2, len1, len2;
   logic                   ge1, ge2;
   logic [1:0]             digit;
   logic                   finished;
   logic                   rising_decay;
   logic [COUNT_WIDTH:0]   index_inc;
   logic [LEVEL_WIDTH-1:0] ramp_level;

   always_comb begin
      unique case (phase_ff)
         PH_ATTACK:  cur_len = attack_len_ff;
         PH_HOLD:    cur_len = hold_len_ff;
         PH_DECAY:   cur_len = decay_len_ff;
         PH_SUSTAIN: cur_len = sustain_len_ff;
         PH_RELEASE: cur_len = release_len_ff;
         default:    cur_len = '0;
      endcase
   end

   assign finished     = (index_ff >= total_len_ff);
   assign rising_decay = (sustain_level_ff >= peak_level_ff);
   assign index_inc    = {1'b0, index_ff} + (COUNT_WIDTH+1)'(1);

   // one digit: r2 = 2r + bit*k < 3*len, digit in 0..2
   assign r2    = {1'b0, r_ff, 1'b0} + (a_ff[LEVEL_WIDTH-1] ? {2'b00, k_ff} : '0);
   assign len1  = {2'b00, len_ff};
   assign len2  = {1'b0, len_ff, 1'b0};
   assign ge2   = (r2 >= len2);
   assign ge1   = (r2 >= len1);
   assign digit = ge2 ? 2'd2 : (ge1 ? 2'd1 : 2'd0);

   always_comb begin
      unique case (phase_ff)
         PH_ATTACK:  ramp_level = q_ff;
         PH_HOLD:    ramp_level = peak_level_ff;
         PH_DECAY:   ramp_level = rising_decay ? peak_level_ff + q_ff : peak_level_ff - q_ff;
         PH_SUSTAIN: ramp_level = sustain_level_ff;
         PH_RELEASE: ramp_level = sustain_level_ff - q_ff;
         default:    ramp_level = '0;
      endcase
   end

   always_comb begin
      index_in = index_ff;
      pos_in   = pos_ff;
      phase_in = phase_ff;
      a_in     = a_ff;
      k_in     = k_ff;
      len_in   = len_ff;
      r_in     = r_ff;
      q_in     = q_ff;
      cnt_in   = cnt_ff;

      if (cmd.start && cmd.restart) begin
         index_in = '0;
         pos_in   = '0;
         phase_in = PH_ATTACK;
      end
      if (cmd.advance) begin
         phase_in = phase_ff + PHASE_WIDTH'(1);
         pos_in   = '0;
      end
      if (cmd.md_init) begin
         unique case (phase_ff)
            PH_ATTACK:  a_in = peak_level_ff;
            PH_DECAY:   a_in = rising_decay ? sustain_level_ff - peak_level_ff
                                            : peak_level_ff - sustain_level_ff;
            PH_RELEASE: a_in = sustain_level_ff;
            default:    a_in = '0;
         endcase
         k_in   = pos_ff;
         len_in = cur_len;
         r_in   = '0;
         q_in   = '0;
         cnt_in = STEP_CNT_WIDTH'(LEVEL_WIDTH - 1);
      end
      if (cmd.md_step) begin
         a_in   = {a_ff[LEVEL_WIDTH-2:0], 1'b0};
         r_in   = ge2 ? COUNT_WIDTH'(r2 - len2) : (ge1 ? COUNT_WIDTH'(r2 - len1)
                                                       : COUNT_WIDTH'(r2));
         q_in   = {q_ff[LEVEL_WIDTH-2:0], 1'b0} + LEVEL_WIDTH'(digit);
         cnt_in = cnt_ff - STEP_CNT_WIDTH'(1);
      end
      if (cmd.emit && !finished) begin
         index_in = index_inc[COUNT_WIDTH-1:0];
         pos_in   = (phase_ff < PH_TAIL) ? pos_ff + COUNT_WIDTH'(1) : '0;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      out_level_in = out_level_ff;
      out_phase_in = out_phase_ff;
      out_last_in  = out_last_ff;
      out_fin_in   = out_fin_ff;
      if (out_valid_ff && rsp_ready) begin
         out_valid_in = 1'b0;
      end
      if (cmd.emit) begin
         out_valid_in = 1'b1;
         if (finished) begin
            out_level_in = '0;
            out_phase_in = PH_TAIL;
            out_last_in  = 1'b0;
            out_fin_in   = 1'b1;
         end else begin
            out_level_in = ramp_level;
            out_phase_in = phase_ff;
            out_last_in  = (index_inc == {1'b0, total_len_ff});
            out_fin_in   = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         attack_len_ff    <= '0;
         hold_len_ff      <= '0;
         decay_len_ff     <= '0;
         sustain_len_ff   <= '0;
         release_len_ff   <= '0;
         total_len_ff     <= '0;
         peak_level_ff    <= PEAK_LEVEL_RESET;
         sustain_level_ff <= SUSTAIN_LEVEL_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            REG_ATTACK_LEN:    attack_len_ff    <= csr_data[COUNT_WIDTH-1:0];
            REG_HOLD_LEN:      hold_len_ff      <= csr_data[COUNT_WIDTH-1:0];
            REG_DECAY_LEN:     decay_len_ff     <= csr_data[COUNT_WIDTH-1:0];
            REG_SUSTAIN_LEN:   sustain_len_ff   <= csr_data[COUNT_WIDTH-1:0];
            REG_RELEASE_LEN:   release_len_ff   <= csr_data[COUNT_WIDTH-1:0];
            REG_TOTAL_LEN:     total_len_ff     <= csr_data[COUNT_WIDTH-1:0];
            REG_PEAK_LEVEL:    peak_level_ff    <= csr_data[LEVEL_WIDTH-1:0];
            REG_SUSTAIN_LEVEL: sustain_level_ff <= csr_data[LEVEL_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         index_ff     <= '0;
         pos_ff       <= '0;
         phase_ff     <= PH_ATTACK;
         out_valid_ff <= 1'b0;
      end else begin
         index_ff     <= index_in;
         pos_ff       <= pos_in;
         phase_ff     <= phase_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff         <= a_in;
      k_ff         <= k_in;
      len_ff       <= len_in;
      r_ff         <= r_in;
      q_ff         <= q_in;
      cnt_ff       <= cnt_in;
      out_level_ff <= out_level_in;
      out_phase_ff <= out_phase_in;
      out_last_ff  <= out_last_in;
      out_fin_ff   <= out_fin_in;
   end

   assign status.finished = finished;
   assign status.advance  = (phase_ff < PH_TAIL) && (pos_ff >= cur_len);
   assign status.md_last  = (cnt_ff == '0);
   assign status.out_free = !out_valid_ff || rsp_ready;

   assign rsp_valid       = out_valid_ff;
   assign rsp_level       = out_level_ff;
   assign rsp_phase       = out_phase_ff;
   assign rsp_last_sample = out_last_ff;
   assign rsp_finished    = out_fin_ff;

endmodule

`default_nettype wire

[hw/rtl/linear_ahdsr_envelope_top.sv]
// Each accepted item skips used-up phases one at a time, runs the
// LEVEL_WIDTH (16) multiply-divide digits and loads the result register once
// it is free; a finished envelope skips the multiply-divide.
// One item is in flight at a time, and a full output register holds it back;
// the next item is taken while a result waits.
// Reset: synchronous; registers to their reset values, envelope at attack.
// ---------------------------------------------------------------------------
// linear_ahdsr_envelope_top
// Linear attack/hold/decay/sustain/release envelope, one sample per item.
// ---------------------------------------------------------------------------
`default_nettype none

module linear_ahdsr_envelope_top
   import lahdsr_pkg::*;
(
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   output logic                            req_ready,
   input  wire logic                       req_restart,
   output logic                            rsp_valid,
   input  wire logic                       rsp_ready,
   output logic [LEVEL_WIDTH-1:0]          rsp_level,
   output logic [PHASE_WIDTH-1:0]          rsp_phase,
   output logic                            rsp_last_sample,
   output logic                            rsp_finished,
   input  wire logic                       csr_valid,
   output logic                            csr_ready,
   input  wire logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire logic [CSR_DATA_WIDTH-1:0]  csr_data
);

   lahdsr_cmd_type    cmd;
   lahdsr_status_type status;

   assign csr_ready = 1'b1;

   lahdsr_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_restart (req_restart),
      .status      (status),
      .cmd         (cmd)
   );

   lahdsr_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .csr_valid       (csr_valid),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .cmd             (cmd),
      .status          (status),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_level       (rsp_level),
      .rsp_phase       (rsp_phase),
      .rsp_last_sample (rsp_last_sample),
      .rsp_finished    (rsp_finished)
   );

endmodule

`default_nettype wire

[hw/rtl/lahdsr_checker.sv]
// ---------------------------------------------------------------------------
// lahdsr_checker
// Port-level checks on the envelope generator, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

module lahdsr_checker
   import lahdsr_pkg::*;
(
   input wire logic                       clock,
   input wire logic                       reset,
   input wire logic                       req_valid,
   input wire logic                       req_ready,
   input wire logic                       rsp_valid,
   input wire logic                       rsp_ready,
   input wire logic [LEVEL_WIDTH-1:0]     rsp_level,
   input wire logic [PHASE_WIDTH-1:0]     rsp_phase,
   input wire logic                       rsp_last_sample,
   input wire logic                       rsp_finished
);

   // a stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_level) && $stable(rsp_phase))
      else $error("stalled result changed");

   // finished samples are silent tail samples
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_finished |-> rsp_level == '0 && rsp_phase == PH_TAIL
                                    && !rsp_last_sample)
      else $error("finished sample not silent");

   // tail phase is silent
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_phase == PH_TAIL |-> rsp_level == '0)
      else $error("tail sample not zero");

   // an item in flight leaves no room to take another
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second item taken while busy");

   // nothing comes out right after reset
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind linear_ahdsr_envelope_top lahdsr_checker u_checker (.*);

`default_nettype wire
